>>> rtl/mfh_pkg.sv
// Shared types, widths and constants for the magnetometer field and heading block.
// Used by the scaling lanes, the heading pipeline, the top level and the checker.
package mfh_pkg;

	localparam int RAW_W   = 16;
	localparam int FIELD_W = 19;
	localparam int HEAD_W  = 16;
	localparam int ANG_W   = 26;
	localparam int K_W     = 13;
	localparam int PROD_W  = 28;
	localparam int TAB_LEN = 24;

	typedef enum logic [1:0] {
		RANGE_30G = 2'd0,
		RANGE_12G = 2'd1,
		RANGE_8G  = 2'd2,
		RANGE_2G  = 2'd3
	} range_t;

	typedef enum logic [2:0] {
		HD_CORDIC   = 3'd0,
		HD_ZERO     = 3'd1,
		HD_PLUS_180 = 3'd2,
		HD_PLUS_90  = 3'd3,
		HD_MINUS_90 = 3'd4
	} head_kind_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] field_x;
		logic signed [FIELD_W-1:0] field_y;
		logic signed [FIELD_W-1:0] field_z;
		logic signed [HEAD_W-1:0]  heading;
	} result_t;

	localparam logic signed [ANG_W-1:0] ANGLE_180 = 26'sd11796480;
	localparam logic signed [HEAD_W-1:0] HEAD_MAX = 16'sd23040;
	localparam logic signed [HEAD_W-1:0] HEAD_90  = 16'sd11520;
	localparam logic signed [FIELD_W-1:0] FIELD_MAX = 19'sd192006;

	localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
		26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
		26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
		26'sd917,     26'sd458,     26'sd229,    26'sd115,
		26'sd57,      26'sd29,      26'sd14,     26'sd7,
		26'sd4,       26'sd2,       26'sd1,      26'sd0
	};

	// Full scale in milligauss divided by five, so that the divisor becomes 2^15 - 1.
	function automatic logic [K_W-1:0] scale_k(input range_t sel);
		logic [K_W-1:0] k;
		unique case (sel)
			RANGE_30G: k = 13'd6000;
			RANGE_12G: k = 13'd2400;
			RANGE_8G:  k = 13'd1600;
			RANGE_2G:  k = 13'd400;
			default:   k = 13'd6000;
		endcase
		return k;
	endfunction

endpackage

>>> rtl/mfh_scale_lane.sv
// One axis lane: scales a raw count to microtesla times 64, rounded to nearest.
// Depends on mfh_pkg; a delay line aligns the result with the heading pipeline.
module mfh_scale_lane #(
	parameter int EXTRA = 15
) (
	input  logic                           clk,
	input  logic signed [mfh_pkg::RAW_W-1:0]   raw,
	input  mfh_pkg::range_t                range_sel,
	output logic signed [mfh_pkg::FIELD_W-1:0] field
);
	import mfh_pkg::*;

	logic [RAW_W:0]       mag;
	logic [PROD_W-1:0]    prod_full;
	logic [PROD_W-1:0]    prod_s1;
	logic                 sign_s1;
	logic [32:0]          m;
	logic [17:0]          q0_s2;
	logic [18:0]          r0_s2;
	logic                 sign_s2;
	logic [3:0]           q1;
	logic [15:0]          r1;
	logic                 corr;
	logic [17:0]          q;
	logic [FIELD_W-1:0]   fv;
	logic signed [FIELD_W-1:0] field_s3;
	logic signed [FIELD_W-1:0] dly_q [EXTRA];

	always_comb begin
		mag       = raw[RAW_W-1] ? (17'd0 - {raw[RAW_W-1], raw}) : {1'b0, raw};
		prod_full = {11'd0, mag} * {15'd0, scale_k(range_sel)};
		m         = {prod_s1, 5'd0} + 33'd16383;
		q1        = r0_s2[18:15];
		r1        = {1'b0, r0_s2[14:0]} + {12'd0, q1};
		corr      = (r1 >= 16'd32767);
		q         = q0_s2 + {14'd0, q1} + {17'd0, corr};
		fv        = {1'b0, q};
	end

	// The quotient by 2^15 - 1 folds the high part back into the low part twice.
	always_ff @(posedge clk) begin
		prod_s1  <= prod_full;
		sign_s1  <= raw[RAW_W-1];
		q0_s2    <= m[32:15];
		r0_s2    <= {4'd0, m[14:0]} + {1'b0, m[32:15]};
		sign_s2  <= sign_s1;
		field_s3 <= sign_s2 ? $signed(19'd0 - fv) : $signed(fv);
	end

	always_ff @(posedge clk) begin
		dly_q[0] <= field_s3;
		for (int k = 1; k < EXTRA; k++) begin
			dly_q[k] <= dly_q[k-1];
		end
	end

	assign field = dly_q[EXTRA-1];

endmodule

>>> rtl/mfh_cordic.sv
// Pipelined vectoring CORDIC giving atan2(-x, y) in degrees times 128.
// Depends on mfh_pkg for the arctangent table and the special-case codes.
module mfh_cordic #(
	parameter int STAGES = 16
) (
	input  logic                            clk,
	input  logic signed [mfh_pkg::RAW_W-1:0]  raw_x,
	input  logic signed [mfh_pkg::RAW_W-1:0]  raw_y,
	output logic signed [mfh_pkg::HEAD_W-1:0] heading
);
	import mfh_pkg::*;

	logic signed [ANG_W-1:0] px, py, nxr;
	logic signed [ANG_W-1:0] ix, iy, iz;
	head_kind_t              kind;
	logic signed [ANG_W-1:0] cx_s [STAGES+1];
	logic signed [ANG_W-1:0] cy_s [STAGES+1];
	logic signed [ANG_W-1:0] cz_s [STAGES+1];
	head_kind_t              kind_s [STAGES+1];
	logic signed [ANG_W-1:0] zf;
	logic [ANG_W-1:0]        zmag;
	logic [ANG_W:0]          zsum;
	logic [17:0]             zq;
	logic [HEAD_W-1:0]       qc;
	logic signed [HEAD_W-1:0] hval;
	logic signed [HEAD_W-1:0] head_s;

	always_comb begin
		px  = {{(ANG_W-RAW_W-8){raw_y[RAW_W-1]}}, raw_y, 8'd0};
		nxr = {{(ANG_W-RAW_W-8){raw_x[RAW_W-1]}}, raw_x, 8'd0};
		py  = -nxr;
		if (raw_x == '0) begin
			kind = raw_y[RAW_W-1] ? HD_PLUS_180 : HD_ZERO;
		end else if (raw_y == '0) begin
			kind = raw_x[RAW_W-1] ? HD_PLUS_90 : HD_MINUS_90;
		end else begin
			kind = HD_CORDIC;
		end
		if (px < 0) begin
			iz = (py > 0) ? ANGLE_180 : -ANGLE_180;
			ix = -px;
			iy = -py;
		end else begin
			iz = '0;
			ix = px;
			iy = py;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0]   <= ix;
		cy_s[0]   <= iy;
		cz_s[0]   <= iz;
		kind_s[0] <= kind;
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		always_ff @(posedge clk) begin
			kind_s[i+1] <= kind_s[i];
			if (cy_s[i][ANG_W-1]) begin
				cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] - ATAN_TAB[i];
			end else begin
				cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] + ATAN_TAB[i];
			end
		end
	end

	always_comb begin
		zf   = cz_s[STAGES];
		zmag = zf[ANG_W-1] ? ANG_W'(-zf) : ANG_W'(zf);
		zsum = {1'b0, zmag} + 27'd256;
		zq   = zsum[26:9];
		qc   = (zq > 18'(HEAD_MAX)) ? HEAD_MAX : zq[HEAD_W-1:0];
		case (kind_s[STAGES])
			HD_ZERO:     hval = '0;
			HD_PLUS_180: hval = HEAD_MAX;
			HD_PLUS_90:  hval = HEAD_90;
			HD_MINUS_90: hval = -HEAD_90;
			default:     hval = zf[ANG_W-1] ? $signed(16'd0 - qc) : $signed(qc);
		endcase
	end

	always_ff @(posedge clk) begin
		head_s <= hval;
	end

	assign heading = head_s;

endmodule

>>> rtl/magnetometer_field_and_heading.sv
// Top level: three scaling lanes and the heading pipeline, merged into an output queue.
// Depends on mfh_pkg, mfh_scale_lane and mfh_cordic.
//
//   channel  signals                              beat
//   cfg      range_select_we, range_select_wdata  one register write
//   in       in_valid, in_ready, raw_x/y/z        one raw sample
//   out      out_valid, out_ready, field_x/y/z,   one scaled sample
//            heading
//
// A beat is taken every cycle while in_ready is high; its result passes through
// the CORDIC input stage, the CORDIC stages and the rounding stage to the output queue.
// The queue holds CORDIC_STAGES + 4 results, and in_ready drops only when that many
// beats are accepted and not yet delivered, so stalls on the output absorb that slack.
// Reset clears the range register to 30 gauss and empties the queue.
module magnetometer_field_and_heading #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             range_select_we,
	input  logic [1:0]                       range_select_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [mfh_pkg::RAW_W-1:0]   raw_x,
	input  logic signed [mfh_pkg::RAW_W-1:0]   raw_y,
	input  logic signed [mfh_pkg::RAW_W-1:0]   raw_z,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [mfh_pkg::FIELD_W-1:0] field_x,
	output logic signed [mfh_pkg::FIELD_W-1:0] field_y,
	output logic signed [mfh_pkg::FIELD_W-1:0] field_z,
	output logic signed [mfh_pkg::HEAD_W-1:0]  heading
);
	import mfh_pkg::*;

	localparam int LAT   = CORDIC_STAGES + 2;
	localparam int DEPTH = LAT + 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);

	range_t                    range_q;
	logic [LAT-1:0]            vld_q;
	logic [OCC_W-1:0]          occ_q;
	logic [OCC_W-1:0]          cnt_q;
	logic [PTR_W-1:0]          wr_ptr_q, rd_ptr_q;
	result_t                   fifo_q [DEPTH];
	result_t                   merged;
	logic                      in_acc, out_acc, wr_en;
	logic signed [FIELD_W-1:0] lane_x, lane_y, lane_z;
	logic signed [HEAD_W-1:0]  lane_h;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign wr_en   = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= RANGE_30G;
		end else if (range_select_we) begin
			range_q <= range_t'(range_select_wdata);
		end
	end

	mfh_scale_lane #(.EXTRA(CORDIC_STAGES - 1)) u_lane_x (
		.clk(clk), .raw(raw_x), .range_sel(range_q), .field(lane_x)
	);
	mfh_scale_lane #(.EXTRA(CORDIC_STAGES - 1)) u_lane_y (
		.clk(clk), .raw(raw_y), .range_sel(range_q), .field(lane_y)
	);
	mfh_scale_lane #(.EXTRA(CORDIC_STAGES - 1)) u_lane_z (
		.clk(clk), .raw(raw_z), .range_sel(range_q), .field(lane_z)
	);
	mfh_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk(clk), .raw_x(raw_x), .raw_y(raw_y), .heading(lane_h)
	);

	always_comb begin
		merged.field_x = lane_x;
		merged.field_y = lane_y;
		merged.field_z = lane_z;
		merged.heading = lane_h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			occ_q    <= '0;
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], in_acc};
			if (in_acc && !out_acc) begin
				occ_q <= occ_q + 1'b1;
			end else if (!in_acc && out_acc) begin
				occ_q <= occ_q - 1'b1;
			end
			if (wr_en && !out_acc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr_en && out_acc) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (out_acc) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_q[wr_ptr_q] <= merged;
		end
	end

	assign in_ready  = (occ_q < OCC_W'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign field_x   = fifo_q[rd_ptr_q].field_x;
	assign field_y   = fifo_q[rd_ptr_q].field_y;
	assign field_z   = fifo_q[rd_ptr_q].field_z;
	assign heading   = fifo_q[rd_ptr_q].heading;

endmodule

>>> rtl/mfh_checker.sv
// Port-level checks for the magnetometer field and heading block.
// Depends on mfh_pkg; bound to the top level at the end of this file.
module mfh_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic signed [mfh_pkg::RAW_W-1:0]   raw_x,
	input logic signed [mfh_pkg::RAW_W-1:0]   raw_y,
	input logic signed [mfh_pkg::RAW_W-1:0]   raw_z,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [mfh_pkg::FIELD_W-1:0] field_x,
	input logic signed [mfh_pkg::FIELD_W-1:0] field_y,
	input logic signed [mfh_pkg::FIELD_W-1:0] field_z,
	input logic signed [mfh_pkg::HEAD_W-1:0]  heading
);
	import mfh_pkg::*;

	// A stalled sample beat keeps its valid and its payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(raw_x) && $stable(raw_y)
			&& $stable(raw_z))
		else $error("stalled sample beat changed");

	// A stalled result beat keeps its valid and its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(field_x) && $stable(field_y)
			&& $stable(field_z) && $stable(heading))
		else $error("stalled result beat changed");

	// The input side only backs off when results are queued for delivery.
	a_ready_backs: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading <= HEAD_MAX && heading >= -HEAD_MAX)
		else $error("heading out of range");

	a_field_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> field_x <= FIELD_MAX && field_x >= -FIELD_MAX
			&& field_y <= FIELD_MAX && field_y >= -FIELD_MAX
			&& field_z <= FIELD_MAX && field_z >= -FIELD_MAX)
		else $error("field out of range");

endmodule

bind magnetometer_field_and_heading mfh_checker u_mfh_checker (.*);

>>> sim/testbench.sv
// Self-checking testbench for magnetometer_field_and_heading: a queue-fed driver, a stalling
// monitor and an in-bench predictor for field scaling and the CORDIC compass heading.
// Depends on mfh_pkg and the magnetometer_field_and_heading RTL.
module testbench;
	import mfh_pkg::*;

	localparam int STAGES = 16;
	localparam int ROUND_TAB_LEN = 24;
	localparam longint HALF_TURN = 64'sd11796480;
	localparam longint FIELD_DIV = 64'sd327670;
	localparam longint FIELD_BIAS = 64'sd163835;
	localparam int RANDOM_PER_PHASE = 160;
	localparam range_t RANDOM_PHASES [5] = '{RANGE_2G, RANGE_12G, RANGE_8G, RANGE_30G, RANGE_2G};
	localparam longint ATAN_STEP [ROUND_TAB_LEN] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct packed {
		logic signed [RAW_W-1:0] x;
		logic signed [RAW_W-1:0] y;
		logic signed [RAW_W-1:0] z;
	} sample_t;

	logic clk;
	logic arst_n = 1'b0;
	logic range_select_we = 1'b0;
	logic [1:0] range_select_wdata = 2'd0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [RAW_W-1:0] raw_x = '0;
	logic signed [RAW_W-1:0] raw_y = '0;
	logic signed [RAW_W-1:0] raw_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [FIELD_W-1:0] field_x;
	logic signed [FIELD_W-1:0] field_y;
	logic signed [FIELD_W-1:0] field_z;
	logic signed [HEAD_W-1:0] heading;

	sample_t samples_to_send [$];
	result_t expected_results [$];
	range_t active_range = RANGE_30G;
	int mismatches = 0;
	int samples_checked = 0;
	int ranges_used = 0;

	magnetometer_field_and_heading #(
		.CORDIC_STAGES(STAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.range_select_we(range_select_we),
		.range_select_wdata(range_select_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_x(raw_x),
		.raw_y(raw_y),
		.raw_z(raw_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.field_x(field_x),
		.field_y(field_y),
		.field_z(field_z),
		.heading(heading)
	);

	function automatic logic signed [FIELD_W-1:0] scaled_field(input logic signed [RAW_W-1:0] raw,
			input range_t sel);
		longint full_mg;
		longint num;
		longint q;
		case (sel)
			RANGE_30G: full_mg = 30000;
			RANGE_12G: full_mg = 12000;
			RANGE_8G:  full_mg = 8000;
			default:   full_mg = 2000;
		endcase
		num = longint'(raw) * full_mg * 64;
		q = ((num < 0 ? -num : num) + FIELD_BIAS) / FIELD_DIV;
		return FIELD_W'((num < 0) ? -q : q);
	endfunction

	function automatic logic signed [HEAD_W-1:0] compass_heading(input logic signed [RAW_W-1:0] rx,
			input logic signed [RAW_W-1:0] ry);
		longint vx;
		longint vy;
		longint ang;
		longint nx;
		longint h;
		if (rx == 0)
			return (ry < 0) ? HEAD_MAX : '0;
		if (ry == 0)
			return (rx < 0) ? HEAD_90 : -HEAD_90;
		vx = longint'(ry) * 256;
		vy = -longint'(rx) * 256;
		ang = 0;
		if (vx < 0) begin
			ang = (vy > 0) ? HALF_TURN : -HALF_TURN;
			vx = -vx;
			vy = -vy;
		end
		for (int i = 0; i < STAGES && i < ROUND_TAB_LEN; i++) begin
			if (vy >= 0) begin
				nx = vx + (vy >>> i);
				vy = vy - (vx >>> i);
				ang = ang + ATAN_STEP[i];
			end else begin
				nx = vx - (vy >>> i);
				vy = vy + (vx >>> i);
				ang = ang - ATAN_STEP[i];
			end
			vx = nx;
		end
		h = ((ang < 0 ? -ang : ang) + 256) / 512;
		if (ang < 0)
			h = -h;
		if (h > longint'(HEAD_MAX))
			h = longint'(HEAD_MAX);
		if (h < -longint'(HEAD_MAX))
			h = -longint'(HEAD_MAX);
		return HEAD_W'(h);
	endfunction

	function automatic result_t predict_result(input sample_t s, input range_t sel);
		result_t r;
		r.field_x = scaled_field(s.x, sel);
		r.field_y = scaled_field(s.y, sel);
		r.field_z = scaled_field(s.z, sel);
		r.heading = compass_heading(s.x, s.y);
		return r;
	endfunction

	function automatic logic signed [RAW_W-1:0] random_raw();
		int unsigned pick;
		pick = $urandom_range(0, 15);
		case (pick)
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			3: return 16'sd1;
			4: return -16'sd1;
			5, 6: return RAW_W'($signed($urandom_range(0, 64)) - 32);
			default: return RAW_W'($urandom);
		endcase
	endfunction

	task automatic queue_sample(input int x, input int y, input int z);
		sample_t s;
		s.x = RAW_W'(x);
		s.y = RAW_W'(y);
		s.z = RAW_W'(z);
		samples_to_send.push_back(s);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (samples_to_send.size() != 0 || in_valid || expected_results.size() != 0);
	endtask

	task automatic write_range(input range_t sel);
		@(posedge clk);
		range_select_we <= 1'b1;
		range_select_wdata <= sel;
		@(posedge clk);
		range_select_we <= 1'b0;
		active_range = sel;
		ranges_used++;
	endtask

	task automatic compare_field(input string fname, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk) begin : sample_driver
		int burst_left;
		int gap_left;
		sample_t held;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				held.x = raw_x;
				held.y = raw_y;
				held.z = raw_z;
				expected_results.push_back(predict_result(held, active_range));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (samples_to_send.size() != 0) begin
					held = samples_to_send.pop_front();
					in_valid <= 1'b1;
					raw_x <= held.x;
					raw_y <= held.y;
					raw_z <= held.z;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: ready follows a 32-bit pattern that is redrawn in one of four densities.
	always @(posedge clk) begin : result_monitor
		logic [31:0] ready_pattern;
		int pattern_pos;
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			pattern_pos = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected beat, expected none, got %0d %0d %0d %0d",
						$time, field_x, field_y, field_z, heading);
				end else begin
					want = expected_results.pop_front();
					samples_checked++;
					compare_field("field_x", want.field_x, field_x);
					compare_field("field_y", want.field_y, field_y);
					compare_field("field_z", want.field_z, field_z);
					compare_field("heading", want.heading, heading);
				end
			end
			if (pattern_pos == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pattern = '1;
					1: ready_pattern = $urandom;
					2: ready_pattern = $urandom & $urandom;
					default: ready_pattern = $urandom | $urandom;
				endcase
			end
			out_ready <= ready_pattern[pattern_pos];
			pattern_pos = (pattern_pos + 1) % 32;
		end
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		write_range(RANGE_30G);

		queue_sample(0, 0, 0);
		queue_sample(32767, 32767, 32767);
		queue_sample(-32768, -32768, -32768);
		queue_sample(0, -5, 1);
		queue_sample(0, -32768, -1);
		queue_sample(0, 123, 32767);
		queue_sample(0, 32767, -32768);
		queue_sample(100, 0, 7);
		queue_sample(-100, 0, -7);
		queue_sample(32767, 0, 0);
		queue_sample(-32768, 0, 0);
		queue_sample(1, 1, 1);
		queue_sample(-1, -1, -1);
		queue_sample(1, -1, 2);
		queue_sample(-1, 1, -2);
		queue_sample(32767, -32768, 5);
		queue_sample(-32768, 32767, -5);
		queue_sample(1, -32768, 3);
		queue_sample(-1, -32768, -3);
		queue_sample(32767, -1, 12345);
		queue_sample(-32768, -1, -12345);
		queue_sample(-20000, 15000, 2);

		foreach (RANDOM_PHASES[p]) begin
			wait_drained();
			write_range(RANDOM_PHASES[p]);
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				queue_sample(random_raw(), random_raw(), random_raw());
		end

		wait_drained();
		repeat (STAGES + 8) @(posedge clk);
		$display("Checked %0d samples across %0d range settings, with axis extremes,",
			samples_checked, ranges_used);
		$display("zero-axis headings and random bursts against a stalling receiver.");
		if (mismatches == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> magnetometer_field_and_heading.f
rtl/mfh_pkg.sv
rtl/mfh_scale_lane.sv
rtl/mfh_cordic.sv
rtl/magnetometer_field_and_heading.sv
rtl/mfh_checker.sv
sim/testbench.sv
